[sv/ordered_table_delete_upper_bound_assert.svh]
// Assertion macros shared by the modules of the ordered table block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ORDERED_TABLE_DELETE_UPPER_BOUND_ASSERT_SVH
`define ORDERED_TABLE_DELETE_UPPER_BOUND_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTDUB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OTDUB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/otdub_pkg.sv]
package otdub_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int ID_W     = 11;
  localparam int VAL_W    = 32;
  localparam int OP_W     = 2;
  localparam int STAT_W   = 2;

  // Input tdata layout, lowest bit first.
  localparam int IN_ID_LSB  = 0;
  localparam int IN_VAL_LSB = IN_ID_LSB + ID_W;
  localparam int IN_KEY_LSB = IN_VAL_LSB + VAL_W;
  localparam int IN_BITS    = IN_KEY_LSB + VAL_W;
  localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_INSERT       = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR        = 2'd2;

  localparam logic [STAT_W-1:0] ST_FOUND  = 2'd0;
  localparam logic [STAT_W-1:0] ST_NONE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture id and key of the accepted transaction
    logic ins_write;   // write the accepted insert into the table
    logic clr_start;   // rewind the sweep counter for a clearing pass
    logic clr_write;   // clear the entry under the sweep counter
    logic del_write;   // clear the presence of the captured id
    logic scan_start;  // rewind the sweep counter and forget the best entry
    logic scan_read;   // read the entry under the sweep counter for the scan
    logic out_absent;  // load an absent-id result
    logic out_scan;    // load the result of the finished scan
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic id_ok;     // captured id lies within the table
    logic hit;       // presence bit of the entry just read
    logic cnt_last;  // sweep counter is on the last entry
    logic out_free;  // output register can take a result this cycle
  } stat_t;

  function automatic logic id_in_range(input logic [ID_W-1:0] id);
    return (id != '0) && (id <= ID_W'(CAPACITY));
  endfunction

  function automatic logic [ADDR_W-1:0] id_to_addr(input logic [ID_W-1:0] id);
    logic [ID_W-1:0] t;
    t = id - ID_W'(1);
    return t[ADDR_W-1:0];
  endfunction

endpackage

[sv/ordered_table_delete_upper_bound.sv]
// Ordered table with remove-then-upper-bound query. The block holds one signed
// 32-bit value and a presence bit for each id from 1 to 1024. An insert
// (opcode 0) stores a value under an id and marks it present; an id of 0 or
// above 1024 is ignored. A remove-and-query (opcode 1) removes the given id and
// then answers, in one output transaction, the id of the present entry with
// the smallest value strictly above the search key, the lowest id winning on
// equal values; status is 0 when found, 1 when no value lies above the key and
// 2 when the id was not present (the table is then left untouched). found_id
// is 0 unless status is 0. A clear (opcode 2) drops every entry; opcode 3 is
// ignored. Neither insert nor clear nor opcode 3 produces an output
// transaction. An insert is written into the table in the cycle in which it is
// accepted. A remove-and-query passes through the accepting cycle, the read of
// the entry under the removed id, the check of its presence, a scan that reads
// every table entry once through the single read port of the table memory, a
// final compare and the load of the output register; a remove of an absent id
// skips the scan, and one whose id lies outside 1 to 1024 also skips the
// presence check. Any remove waits longer while an earlier result still sits
// unread in the output register. A clear writes one table word per cycle.
// After reset the same clearing pass runs before the first input transaction
// is accepted. A finished result waits in an output register, and further
// inserts and clears are taken while it waits.
module ordered_table_delete_upper_bound (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // entry_id [10:0], entry_value [42:11], search_key [74:43], zeros above
  input  logic [otdub_pkg::IN_DATA_W-1:0]   s_tdata,
  // opcode [1:0]
  input  logic [otdub_pkg::OP_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // found_id [10:0], zeros above
  output logic [otdub_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [otdub_pkg::STAT_W-1:0]      m_tuser
);

  otdub_pkg::cmd_t  cmd;
  otdub_pkg::stat_t st;

  // The controller sequences inserts, clears, the id check and the scan.
  otdub_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .st       (st)
  );

  // The datapath holds the table memory, the sweep counter, the running best
  // entry of the scan and the output register.
  otdub_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

[sv/otdub_ctrl.sv]
`include "ordered_table_delete_upper_bound_assert.svh"

module otdub_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [otdub_pkg::OP_W-1:0]    s_tuser,   // opcode
  output otdub_pkg::cmd_t               cmd,
  input  otdub_pkg::stat_t              st
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CLEAR  = 3'd1;
  localparam logic [2:0] S_CHECK  = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;
  localparam logic [2:0] S_DRAIN  = 3'd5;
  localparam logic [2:0] S_ABSENT = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          unique case (s_tuser)
            otdub_pkg::OP_INSERT: begin
              cmd.ins_write = 1'b1;
            end
            otdub_pkg::OP_REMOVE_QUERY: begin
              state_next = S_CHECK;
            end
            otdub_pkg::OP_CLEAR: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (st.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      S_CHECK: begin
        state_next = st.id_ok ? S_TEST : S_ABSENT;
      end
      S_TEST: begin
        if (st.hit) begin
          cmd.del_write  = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          state_next = S_ABSENT;
        end
      end
      S_SCAN: begin
        cmd.scan_read = 1'b1;
        if (st.cnt_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_ABSENT: begin
        if (st.out_free) begin
          cmd.out_absent = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_scan = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Reset starts with a clearing pass over the whole table.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `OTDUB_ASSERT_NOW(a_del_only_present, cmd.del_write, st.hit && st.id_ok, "removal of absent entry")
  `OTDUB_ASSERT_NOW(a_load_when_free, cmd.out_absent || cmd.out_scan, st.out_free, "result overwritten")
  `OTDUB_ASSERT_NEXT(a_remove_checks, accept && (s_tuser == otdub_pkg::OP_REMOVE_QUERY), state == S_CHECK, "remove not checked")

endmodule

[sv/otdub_dp.sv]
`include "ordered_table_delete_upper_bound_assert.svh"

module otdub_dp (
  input  logic                              clk,
  input  logic                              rst,
  // entry_id, entry_value, search_key from bit 0 up, zero padded
  input  logic [otdub_pkg::IN_DATA_W-1:0]   s_tdata,
  input  otdub_pkg::cmd_t                   cmd,
  output otdub_pkg::stat_t                  st,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // found_id from bit 0 up, zero padded
  output logic [otdub_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [otdub_pkg::STAT_W-1:0]      m_tuser    // status
);

  localparam int AW = otdub_pkg::ADDR_W;
  localparam int IW = otdub_pkg::ID_W;
  localparam int VW = otdub_pkg::VAL_W;

  logic [IW-1:0]        in_id;
  logic signed [VW-1:0] in_val;
  logic signed [VW-1:0] in_key;

  // Each word holds the presence bit above the value.
  logic [VW:0]          table_mem [otdub_pkg::CAPACITY];
  logic                 we;
  logic [AW-1:0]        wa;
  logic [VW:0]          wd;
  logic [AW-1:0]        ra;
  logic [VW:0]          rd_data;

  logic [IW-1:0]        id_reg;
  logic signed [VW-1:0] key_reg;
  logic [AW-1:0]        cnt;
  logic                 cmp_valid;
  logic [AW-1:0]        cmp_idx;
  logic                 have;
  logic signed [VW-1:0] best_val;
  logic [AW-1:0]        best_idx;
  logic signed [VW-1:0] rd_val;
  logic                 better;

  logic                 out_valid;
  logic [otdub_pkg::STAT_W-1:0] out_status;
  logic [IW-1:0]        out_id;

  assign in_id  = s_tdata[otdub_pkg::IN_ID_LSB +: IW];
  assign in_val = s_tdata[otdub_pkg::IN_VAL_LSB +: VW];
  assign in_key = s_tdata[otdub_pkg::IN_KEY_LSB +: VW];

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd.ins_write && otdub_pkg::id_in_range(in_id)) begin
      we = 1'b1;
      wa = otdub_pkg::id_to_addr(in_id);
      wd = {1'b1, in_val};
    end else if (cmd.clr_write) begin
      we = 1'b1;
      wa = cnt;
    end else if (cmd.del_write) begin
      we = 1'b1;
      wa = otdub_pkg::id_to_addr(id_reg);
    end
  end

  assign ra = cmd.scan_read ? cnt : otdub_pkg::id_to_addr(id_reg);

  always_ff @(posedge clk) begin
    if (we) begin
      table_mem[wa] <= wd;
    end
    rd_data <= table_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_reg  <= in_id;
      key_reg <= in_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_read;
      if (cmd.clr_start || cmd.scan_start) begin
        cnt <= '0;
      end else if (cmd.clr_write || cmd.scan_read) begin
        cnt <= cnt + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cnt;
  end

  // Ascending scan with a strict compare keeps the lowest id on equal values.
  assign rd_val = rd_data[VW-1:0];
  assign better = cmp_valid && rd_data[VW] && (rd_val > key_reg)
                  && (!have || (rd_val < best_val));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.scan_start) begin
      have <= 1'b0;
    end else if (better) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (better) begin
      best_val <= rd_val;
      best_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_absent || cmd.out_scan) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_absent) begin
      out_status <= otdub_pkg::ST_ABSENT;
      out_id     <= '0;
    end else if (cmd.out_scan) begin
      out_status <= have ? otdub_pkg::ST_FOUND : otdub_pkg::ST_NONE;
      out_id     <= have ? (IW'(best_idx) + IW'(1)) : '0;
    end
  end

  assign st.id_ok    = otdub_pkg::id_in_range(id_reg);
  assign st.hit      = rd_data[VW];
  assign st.cnt_last = (cnt == AW'(otdub_pkg::CAPACITY - 1));
  assign st.out_free = !out_valid || m_tready;

  assign m_tvalid = out_valid;
  assign m_tuser  = out_status;
  assign m_tdata  = {{(otdub_pkg::OUT_DATA_W - IW){1'b0}}, out_id};

  `OTDUB_ASSERT_NOW(a_rise_needs_load, $rose(out_valid), $past(cmd.out_absent || cmd.out_scan), "result without load")
  `OTDUB_ASSERT_NOW(a_no_id_unless_found, out_valid && (out_status != otdub_pkg::ST_FOUND), out_id == '0, "id on miss")
  `OTDUB_ASSERT_NOW(a_found_id_range, out_valid && (out_status == otdub_pkg::ST_FOUND), otdub_pkg::id_in_range(out_id), "bad found id")

endmodule
